// ===== hdl/gte_pkg.sv =====
// Shared types, constants and helper functions for the generalized-time converter.
package gte_pkg;

  localparam logic [7:0] DIGIT_ZERO = 8'd48;
  localparam logic [7:0] DIGIT_NINE = 8'd57;

  localparam logic [3:0] TS_LEN     = 4'd14;
  localparam logic [3:0] LAST_POS   = 4'd13;
  localparam logic [3:0] YEAR_END   = 4'd4;
  localparam logic [3:0] MONTH_END  = 4'd6;
  localparam logic [3:0] DAY_END    = 4'd8;
  localparam logic [3:0] HOUR_END   = 4'd10;
  localparam logic [3:0] MINUTE_END = 4'd12;

  // Days from 0000-03-01 (shifted by 400 years) to 1970-01-01.
  localparam logic [22:0] DAY_OFFSET = 23'd865565;

  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic        err;
  } gte_fields_t;

  function automatic logic [13:0] push_year(input logic [13:0] acc, input logic [3:0] d);
    logic [17:0] t;
    t = 18'(acc) * 18'd10 + 18'(d);
    return t[13:0];
  endfunction

  function automatic logic [6:0] push_field(input logic [6:0] acc, input logic [3:0] d);
    logic [10:0] t;
    t = 11'(acc) * 11'd10 + 11'(d);
    return t[6:0];
  endfunction

  // Day of a March-based year on which month index mm starts.
  function automatic logic [8:0] month_start(input logic [3:0] mm);
    logic [8:0] r;
    case (mm)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/gte_accum.sv =====
// Character accumulator: builds the six digit fields of one timestamp.
module gte_accum (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_fire,
  input  logic [7:0]          char_code,
  input  logic                first,
  output logic                res_valid,
  output gte_pkg::gte_fields_t res_fields
);
  import gte_pkg::*;

  logic [3:0]  position, position_next;
  logic [13:0] year_acc, year_acc_next;
  logic [6:0]  month_acc, month_acc_next;
  logic [6:0]  day_acc, day_acc_next;
  logic [6:0]  hour_acc, hour_acc_next;
  logic [6:0]  minute_acc, minute_acc_next;
  logic [6:0]  second_acc, second_acc_next;
  logic        error_seen, error_seen_next;

  logic [3:0]  pos_base;
  logic [13:0] year_base;
  logic [6:0]  month_base, day_base, hour_base, minute_base, second_base;
  logic        err_base;
  logic        is_digit;
  logic [3:0]  digit;
  logic [7:0]  digit_raw;

  always_comb begin
    pos_base    = first ? '0 : position;
    year_base   = first ? '0 : year_acc;
    month_base  = first ? '0 : month_acc;
    day_base    = first ? '0 : day_acc;
    hour_base   = first ? '0 : hour_acc;
    minute_base = first ? '0 : minute_acc;
    second_base = first ? '0 : second_acc;
    err_base    = first ? 1'b0 : error_seen;

    is_digit  = (char_code >= DIGIT_ZERO) && (char_code <= DIGIT_NINE);
    digit_raw = char_code - DIGIT_ZERO;
    digit     = is_digit ? digit_raw[3:0] : 4'd0;

    position_next   = position;
    year_acc_next   = year_acc;
    month_acc_next  = month_acc;
    day_acc_next    = day_acc;
    hour_acc_next   = hour_acc;
    minute_acc_next = minute_acc;
    second_acc_next = second_acc;
    error_seen_next = error_seen;

    if (char_fire) begin
      position_next   = pos_base;
      year_acc_next   = year_base;
      month_acc_next  = month_base;
      day_acc_next    = day_base;
      hour_acc_next   = hour_base;
      minute_acc_next = minute_base;
      second_acc_next = second_base;
      error_seen_next = err_base;
      if (pos_base < TS_LEN) begin
        error_seen_next = err_base | ~is_digit;
        position_next   = pos_base + 4'd1;
        if (pos_base < YEAR_END) begin
          year_acc_next = push_year(year_base, digit);
        end else if (pos_base < MONTH_END) begin
          month_acc_next = push_field(month_base, digit);
        end else if (pos_base < DAY_END) begin
          day_acc_next = push_field(day_base, digit);
        end else if (pos_base < HOUR_END) begin
          hour_acc_next = push_field(hour_base, digit);
        end else if (pos_base < MINUTE_END) begin
          minute_acc_next = push_field(minute_base, digit);
        end else begin
          second_acc_next = push_field(second_base, digit);
        end
      end
    end
  end

  assign res_valid         = char_fire && (pos_base == LAST_POS);
  assign res_fields.year   = year_acc_next;
  assign res_fields.month  = month_acc_next;
  assign res_fields.day    = day_acc_next;
  assign res_fields.hour   = hour_acc_next;
  assign res_fields.minute = minute_acc_next;
  assign res_fields.second = second_acc_next;
  assign res_fields.err    = error_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      year_acc   <= '0;
      month_acc  <= '0;
      day_acc    <= '0;
      hour_acc   <= '0;
      minute_acc <= '0;
      second_acc <= '0;
      error_seen <= 1'b0;
    end else begin
      position   <= position_next;
      year_acc   <= year_acc_next;
      month_acc  <= month_acc_next;
      day_acc    <= day_acc_next;
      hour_acc   <= hour_acc_next;
      minute_acc <= minute_acc_next;
      second_acc <= second_acc_next;
      error_seen <= error_seen_next;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    position <= TS_LEN)
    else $error("position count ran past the timestamp length");

  a_done_full: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> position == TS_LEN)
    else $error("a result was raised without completing the timestamp");

  a_first_restart: assert property (@(posedge clk) disable iff (rst)
    char_fire && first |=> position == 4'd1)
    else $error("a start marker did not restart the timestamp");

endmodule

// ===== hdl/gte_epoch.sv =====
// Calendar pipeline: turns the accumulated fields into seconds since 1970.
module gte_epoch (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  gte_pkg::gte_fields_t in_fields,
  output logic                 in_free,
  output logic                 epoch_valid,
  input  logic                 epoch_ready,
  output logic signed [38:0]   epoch_seconds,
  output logic                 bad_digit
);
  import gte_pkg::*;

  localparam logic signed [17:0] SEC_PER_DAY = 18'sd86400;

  logic free1, free2, free3, free4, free_o;

  // Stage 1: latched fields.
  logic        v1;
  gte_fields_t f1;

  // Stage 2: shifted year, day within the March-based year, seconds of day.
  logic              v2;
  logic [13:0]       y2;
  logic signed [9:0] dd2;
  logic [18:0]       hms2;
  logic              err2;

  // Stage 3: year terms.
  logic              v3;
  logic [21:0]       y365_3;
  logic [11:0]       y4_3;
  logic [6:0]        c3;
  logic signed [9:0] dd3;
  logic [18:0]       hms3;
  logic              err3;

  // Stage 4: day count.
  logic               v4;
  logic signed [22:0] days4;
  logic [18:0]        hms4;
  logic               err4;

  logic [6:0]  mon_m1;
  logic [12:0] q_prod;
  logic [3:0]  quot;
  logic [6:0]  rem_full;
  logic [3:0]  rem;
  logic [3:0]  mm;
  logic [8:0]  doy;
  logic [13:0] y_next;
  logic [9:0]  dd_sum;
  logic [18:0] hms_next;

  logic [26:0] c_prod;
  logic [6:0]  c_next;
  logic [21:0] y365_next;

  logic [22:0] days_sum;

  logic signed [40:0] day_secs;
  logic signed [38:0] epoch_next;

  assign free_o  = !epoch_valid || epoch_ready;
  assign free4   = !v4 || free_o;
  assign free3   = !v3 || free4;
  assign free2   = !v2 || free3;
  assign free1   = !v1 || free2;
  assign in_free = free1;

  always_comb begin
    mon_m1   = f1.month - 7'd1;
    q_prod   = 13'(mon_m1) * 13'd43;
    quot     = q_prod[12:9];
    rem_full = mon_m1 - 7'(quot) * 7'd12;
    if (f1.month == 7'd0) begin
      rem    = 4'd11;
      y_next = f1.year + 14'd399;
    end else begin
      rem    = rem_full[3:0];
      y_next = f1.year + 14'(quot) + 14'd400 - 14'(rem <= 4'd1);
    end
    mm       = (rem >= 4'd2) ? rem - 4'd2 : rem + 4'd10;
    doy      = month_start(mm);
    dd_sum   = 10'(doy) + 10'(f1.day) - 10'd1;
    hms_next = 19'(f1.hour) * 19'd3600 + 19'(f1.minute) * 19'd60 + 19'(f1.second);
  end

  always_comb begin
    c_prod    = 27'(y2) * 27'd5243;
    c_next    = c_prod[25:19];
    y365_next = 22'(y2) * 22'd365;
  end

  always_comb begin
    days_sum = 23'(y365_3) + 23'(y4_3) - 23'(c3) + 23'(c3[6:2]) + 23'(dd3) - DAY_OFFSET;
  end

  always_comb begin
    day_secs   = days4 * SEC_PER_DAY;
    epoch_next = 39'(day_secs) + 39'(hms4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      v4          <= 1'b0;
      epoch_valid <= 1'b0;
    end else begin
      if (free1) begin
        v1 <= in_valid;
      end
      if (free2) begin
        v2 <= v1;
      end
      if (free3) begin
        v3 <= v2;
      end
      if (free4) begin
        v4 <= v3;
      end
      if (free_o) begin
        epoch_valid <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free1) begin
      f1 <= in_fields;
    end
    if (free2) begin
      y2   <= y_next;
      dd2  <= signed'(dd_sum);
      hms2 <= hms_next;
      err2 <= f1.err;
    end
    if (free3) begin
      y365_3 <= y365_next;
      y4_3   <= y2[13:2];
      c3     <= c_next;
      dd3    <= dd2;
      hms3   <= hms2;
      err3   <= err2;
    end
    if (free4) begin
      days4 <= signed'(days_sum);
      hms4  <= hms3;
      err4  <= err3;
    end
    if (free_o) begin
      epoch_seconds <= epoch_next;
      bad_digit     <= err4;
    end
  end

  a_month_rem: assert property (@(posedge clk) disable iff (rst)
    v1 && (f1.month != 7'd0) |-> rem_full <= 7'd11)
    else $error("month remainder out of range");

  a_century: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (21'(c_next) * 21'd100 <= 21'(y2)) && (21'(y2) < 21'(c_next) * 21'd100 + 21'd100))
    else $error("century quotient does not match the year");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(epoch_valid) |-> $past(v4))
    else $error("result raised without a finished day count");

endmodule

// ===== hdl/gentime_to_epoch.sv =====
// Top level of the generalized-time to Unix epoch converter.
//
//   channel  signals                                  direction  moves
//   char     char_valid, char_ready, char_code, first in         one ASCII character
//   epoch    epoch_valid, epoch_ready,                out        one result per timestamp
//            epoch_seconds, bad_digit
//
// One character transfer can complete in every cycle while the result pipeline has room.
// The fourteenth character of a timestamp reaches epoch_valid through a chain of registers:
// the transfer edge loads the field register, and the month and day stage, the year stage,
// the day-count stage and the output register follow in that order.
// While a result waits at the output, characters are still taken until the result pipeline
// itself is full.
// Reset clears the character position, the digit fields and every pipeline valid bit.
module gentime_to_epoch (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_ready,
  input  logic [7:0]         char_code,
  input  logic               first,
  output logic               epoch_valid,
  input  logic               epoch_ready,
  output logic signed [38:0] epoch_seconds,
  output logic               bad_digit
);
  import gte_pkg::*;

  logic        char_fire;
  logic        res_valid;
  gte_fields_t res_fields;
  logic        pipe_free;

  assign char_ready = pipe_free;
  assign char_fire  = char_valid && pipe_free;

  gte_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .char_fire  (char_fire),
    .char_code  (char_code),
    .first      (first),
    .res_valid  (res_valid),
    .res_fields (res_fields)
  );

  gte_epoch u_epoch (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (res_valid),
    .in_fields     (res_fields),
    .in_free       (pipe_free),
    .epoch_valid   (epoch_valid),
    .epoch_ready   (epoch_ready),
    .epoch_seconds (epoch_seconds),
    .bad_digit     (bad_digit)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench that feeds timestamp characters and checks every epoch result.
module testbench;
  import gte_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int CHAR_TARGET = 1550;

  typedef struct packed {
    logic [38:0] secs;
    logic        bad;
  } epoch_t;

  class stamp_tracker;
    bit [3:0]  pos;
    bit [13:0] year;
    bit [6:0]  month;
    bit [6:0]  day;
    bit [6:0]  hour;
    bit [6:0]  minute;
    bit [6:0]  second;
    bit        err;
    epoch_t    pending_epochs[$];
    int        taken;
    int        mismatches;

    function new();
      clear();
      taken = 0;
      mismatches = 0;
    endfunction

    function void clear();
      pos = 0;
      year = 0;
      month = 0;
      day = 0;
      hour = 0;
      minute = 0;
      second = 0;
      err = 0;
    endfunction

    function longint days_from_civil(longint y, longint m, longint d);
      longint era, yoe, doy, doe;
      if (m <= 2) y = y - 1;
      era = (y >= 0 ? y : y - 399) / 400;
      yoe = y - era * 400;
      doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468;
    endfunction

    function longint epoch_of_fields();
      longint y, mon, days;
      y = longint'(year);
      mon = longint'(month) - 1;
      if (mon < 0) begin
        y = y - 1;
        mon = mon + 12;
      end else begin
        y = y + mon / 12;
        mon = mon % 12;
      end
      days = days_from_civil(y, mon + 1, 1) + longint'(day) - 1;
      return days * 86400 + longint'(hour) * 3600 + longint'(minute) * 60 + longint'(second);
    endfunction

    function void note_char(bit [7:0] c, bit f);
      bit [3:0] d;
      epoch_t   r;
      if (f) clear();
      if (pos >= TS_LEN) return;
      taken++;
      if (c >= DIGIT_ZERO && c <= DIGIT_NINE) begin
        d = 4'(c - DIGIT_ZERO);
      end else begin
        d = 0;
        err = 1;
      end
      if (pos < YEAR_END) year = 14'(year * 10 + d);
      else if (pos < MONTH_END) month = 7'(month * 10 + d);
      else if (pos < DAY_END) day = 7'(day * 10 + d);
      else if (pos < HOUR_END) hour = 7'(hour * 10 + d);
      else if (pos < MINUTE_END) minute = 7'(minute * 10 + d);
      else second = 7'(second * 10 + d);
      pos++;
      if (pos == TS_LEN) begin
        r.secs = 39'(epoch_of_fields());
        r.bad = err;
        pending_epochs.push_back(r);
      end
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    task match_epoch(logic [38:0] secs, logic bad);
      epoch_t r;
      if (pending_epochs.size() == 0) begin
        report($sformatf("unexpected result secs=%0d bad=%b", $signed(secs), bad));
      end else begin
        r = pending_epochs.pop_front();
        if (secs !== r.secs)
          report($sformatf("epoch_seconds %0d, expected %0d", $signed(secs), $signed(r.secs)));
        if (bad !== r.bad)
          report($sformatf("bad_digit %b, expected %b", bad, r.bad));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               char_valid = 1'b0;
  logic               char_ready;
  logic [7:0]         char_code = 8'd0;
  logic               first = 1'b0;
  logic               epoch_valid;
  logic               epoch_ready = 1'b0;
  logic signed [38:0] epoch_seconds;
  logic               bad_digit;

  int send_idle = 0;
  int recv_idle = 0;
  int quiet = 0;
  stamp_tracker book = new();

  gentime_to_epoch uut (
    .clk(clk),
    .rst(rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .char_code(char_code),
    .first(first),
    .epoch_valid(epoch_valid),
    .epoch_ready(epoch_ready),
    .epoch_seconds(epoch_seconds),
    .bad_digit(bad_digit)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && epoch_valid && epoch_ready) book.match_epoch(epoch_seconds, bad_digit);
    epoch_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((char_valid && char_ready) || (epoch_valid && epoch_ready)) quiet = 0;
      else quiet = quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_char(input bit [7:0] c, input bit f);
    if ($urandom_range(99) < send_idle) begin
      char_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code <= c;
    first <= f;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    book.note_char(c, f);
  endtask

  task automatic send_text(input string s, input bit mark);
    for (int i = 0; i < s.len(); i++) send_char(s[i], mark && (i == 0));
  endtask

  function automatic bit [7:0] digit_char(int v, int place);
    return 8'(DIGIT_ZERO + (v / place) % 10);
  endfunction

  task automatic send_random_stamp();
    bit [7:0] chars[14];
    int       fields[6];
    int       len;
    bit       mark;
    if ($urandom_range(99) < 70) fields[0] = $urandom_range(1900, 2100);
    else fields[0] = $urandom_range(9999);
    fields[1] = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(99);
    fields[2] = ($urandom_range(99) < 80) ? $urandom_range(1, 31) : $urandom_range(99);
    fields[3] = ($urandom_range(99) < 80) ? $urandom_range(23) : $urandom_range(99);
    fields[4] = ($urandom_range(99) < 80) ? $urandom_range(59) : $urandom_range(99);
    fields[5] = ($urandom_range(99) < 80) ? $urandom_range(60) : $urandom_range(99);
    for (int k = 0; k < 4; k++) chars[k] = digit_char(fields[0], 1000 / (10 ** k));
    for (int j = 1; j < 6; j++) begin
      chars[2 + 2 * j] = digit_char(fields[j], 10);
      chars[3 + 2 * j] = digit_char(fields[j], 1);
    end
    if ($urandom_range(99) < 10) chars[$urandom_range(13)] = 8'($urandom_range(255));
    len = ($urandom_range(99) < 8) ? $urandom_range(1, 13) : 14;
    mark = ($urandom_range(99) < 95);
    for (int i = 0; i < len; i++) send_char(chars[i], mark && (i == 0));
    if (len == 14 && $urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 3))
        send_char(($urandom_range(1) != 0) ? 8'($urandom_range(255)) : "Z", 1'b0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_idle = 13;
    recv_idle = 86;

    send_text("19700101000000", 1'b0);
    send_text("00000101000000", 1'b1);
    send_text("99991231235959", 1'b1);
    send_text("00000000000000", 1'b1);
    send_text("99999999999999", 1'b1);
    send_text("20000001000000", 1'b1);
    send_text("20000229000000", 1'b1);
    send_text("19000301000000", 1'b1);
    send_char(8'hFF, 1'b1);
    send_char(8'h80, 1'b0);
    send_char(8'h00, 1'b0);
    send_text("00101120000", 1'b0);
    send_text("20A4/1:1z3;59 ", 1'b1);
    send_text("20240229123456", 1'b1);
    send_text("Z99", 1'b0);
    send_text("2024", 1'b1);
    send_text("19991231235959", 1'b1);

    while (book.taken < CHAR_TARGET) begin
      if (book.taken >= (2 * CHAR_TARGET) / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (book.taken >= CHAR_TARGET / 3) begin
        send_idle = 86;
        recv_idle = 13;
      end
      if ($urandom_range(99) < 95) begin
        send_random_stamp();
      end else begin
        repeat ($urandom_range(1, 5)) send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
    char_valid <= 1'b0;

    while (book.pending_epochs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (book.pending_epochs.size() != 0) book.report("results still expected at the end");
    if (book.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
